[rtl/nst_pkg.sv]
// Package for the named semaphore table: sizes, operation and status codes.
package nst_pkg;

  // Table size and name length.
  localparam int ENTRIES    = 8;
  localparam int NAME_BYTES = 20;
  localparam int MAX_BYTES  = 20;
  localparam int NAME_W     = MAX_BYTES * 8;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W      = 16;

  // Operation codes carried by mode_i.
  typedef enum logic [1:0] {
    MODE_OPEN   = 2'd0,
    MODE_WAIT   = 2'd1,
    MODE_POST   = 2'd2,
    MODE_UNLINK = 2'd3
  } mode_e;

  // Status codes returned with every result.
  typedef enum logic [2:0] {
    ST_FOUND      = 3'd0,
    ST_CREATED    = 3'd1,
    ST_FULL       = 3'd2,
    ST_BAD_HANDLE = 3'd3,
    ST_MUST_WAIT  = 3'd4,
    ST_NOT_FOUND  = 3'd5,
    ST_EMPTY      = 3'd6,
    ST_OVERFLOW   = 3'd7
  } status_e;

endpackage

[rtl/named_semaphore_table.sv]
// Top level of the named semaphore table: request register, lookup, update and result register.
//
// Usage:
// - A request item is taken at a rising edge where start_i is high and busy_o is low.
//   busy_o is always low, so a new item may be given in every cycle.
// - The item carries mode_i (open, wait, post, unlink), a 20-byte name split over
//   name_low_i, name_mid_i and name_high_i, initial_count_i and handle_i.
// - The name is cut at its first zero byte when the item is registered.
// - One result item comes out for every request. It passes from the request register
//   into the result register, where it stands on status_o, entry_o, count_after_o
//   and wake_waiter_o for one cycle, marked by done_o.
// - Throughput is one item per cycle. The table is updated in the cycle that builds
//   the result, so the next request already sees the new contents.
// - The receiver cannot stall; a result is shown for exactly one cycle.
// - Reset empties the table at once: all in-use bits clear and no result is pending.
//   Names and counts are not cleared, because an entry is read only once it is in use.
module named_semaphore_table
  import nst_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          mode_i,
  input  logic [63:0]         name_low_i,
  input  logic [63:0]         name_mid_i,
  input  logic [31:0]         name_high_i,
  input  logic [15:0]         initial_count_i,
  input  logic [2:0]          handle_i,
  output logic                done_o,
  output logic [2:0]          status_o,
  output logic [2:0]          entry_o,
  output logic [15:0]         count_after_o,
  output logic                wake_waiter_o
);

  // Request register.
  logic                req_valid_q;
  mode_e               mode_q;
  logic [NAME_W-1:0]   name_q;
  logic [CNT_W-1:0]    init_q;
  logic [2:0]          handle_q;

  // Table storage.
  logic [ENTRIES-1:0]  in_use_q, in_use_d;
  logic [NAME_W-1:0]   key_q   [ENTRIES];
  logic [CNT_W-1:0]    count_q [ENTRIES];

  // Result register.
  logic                done_q;
  status_e             status_q, status_d;
  logic [2:0]          entry_q, entry_d;
  logic [CNT_W-1:0]    cnt_out_q, cnt_out_d;
  logic                wake_q, wake_d;

  // Table write controls.
  logic                key_we;
  logic                cnt_we;
  logic [IDX_W-1:0]    wr_idx;
  logic [CNT_W-1:0]    cnt_wr;

  // Name normalization: clear every byte from the first zero byte on.
  logic [NAME_W-1:0]   name_raw;
  logic [NAME_W-1:0]   name_norm;
  logic [MAX_BYTES:0]  alive;

  assign name_raw = {name_high_i, name_mid_i, name_low_i};

  always_comb begin
    alive[0] = 1'b1;
    for (int b = 0; b < MAX_BYTES; b++) begin
      alive[b+1] = alive[b] && (b < NAME_BYTES) && (name_raw[b*8 +: 8] != 8'd0);
      name_norm[b*8 +: 8] = alive[b+1] ? name_raw[b*8 +: 8] : 8'd0;
    end
  end

  assign busy_o = 1'b0;

  // Request capture.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mode_q   <= mode_e'(mode_i);
      name_q   <= name_norm;
      init_q   <= initial_count_i;
      handle_q <= handle_i;
    end
  end

  // Parallel name compare and lowest free entry.
  logic [IDX_W-1:0]    match_idx, free_idx, hnd_idx, sel_idx;
  logic                match_any, free_any, hnd_ok, name_empty;
  logic [CNT_W-1:0]    cur_cnt;

  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    free_any  = 1'b0;
    free_idx  = '0;
    for (int e = ENTRIES - 1; e >= 0; e--) begin
      if (in_use_q[e] && (key_q[e] == name_q)) begin
        match_any = 1'b1;
        match_idx = IDX_W'(e);
      end
      if (!in_use_q[e]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(e);
      end
    end
  end

  assign name_empty = (name_q[7:0] == 8'd0);
  assign hnd_idx    = IDX_W'(handle_q);
  assign hnd_ok     = (32'(handle_q) < ENTRIES) && in_use_q[hnd_idx];
  assign sel_idx    = ((mode_q == MODE_OPEN) || (mode_q == MODE_UNLINK)) ? match_idx : hnd_idx;
  assign cur_cnt    = count_q[sel_idx];

  // Operation decode: result and table update.
  always_comb begin
    status_d  = ST_FOUND;
    entry_d   = 3'd0;
    cnt_out_d = '0;
    wake_d    = 1'b0;
    in_use_d  = in_use_q;
    key_we    = 1'b0;
    cnt_we    = 1'b0;
    wr_idx    = sel_idx;
    cnt_wr    = '0;
    case (mode_q)
      MODE_OPEN: begin
        if (name_empty) begin
          status_d = ST_EMPTY;
        end else if (match_any) begin
          status_d  = ST_FOUND;
          entry_d   = 3'(match_idx);
          cnt_out_d = cur_cnt;
        end else if (free_any) begin
          status_d         = ST_CREATED;
          entry_d          = 3'(free_idx);
          cnt_out_d        = init_q;
          wr_idx           = free_idx;
          key_we           = 1'b1;
          cnt_we           = 1'b1;
          cnt_wr           = init_q;
          in_use_d[free_idx] = 1'b1;
        end else begin
          status_d = ST_FULL;
        end
      end
      MODE_UNLINK: begin
        if (name_empty) begin
          status_d = ST_EMPTY;
        end else if (match_any) begin
          status_d            = ST_FOUND;
          entry_d             = 3'(match_idx);
          cnt_we              = 1'b1;
          in_use_d[match_idx] = 1'b0;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      MODE_WAIT: begin
        entry_d = handle_q;
        if (!hnd_ok) begin
          status_d = ST_BAD_HANDLE;
        end else if (cur_cnt == '0) begin
          status_d = ST_MUST_WAIT;
        end else begin
          status_d  = ST_FOUND;
          cnt_we    = 1'b1;
          cnt_wr    = cur_cnt - CNT_W'(1);
          cnt_out_d = cnt_wr;
        end
      end
      MODE_POST: begin
        entry_d = handle_q;
        if (!hnd_ok) begin
          status_d = ST_BAD_HANDLE;
        end else if (cur_cnt == '1) begin
          status_d  = ST_OVERFLOW;
          cnt_out_d = cur_cnt;
        end else begin
          status_d  = ST_FOUND;
          cnt_we    = 1'b1;
          cnt_wr    = cur_cnt + CNT_W'(1);
          cnt_out_d = cnt_wr;
          wake_d    = (cur_cnt == '0);
        end
      end
      default: begin
        status_d = ST_FOUND;
      end
    endcase
  end

  // Control state: in-use bits and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= req_valid_q;
      if (req_valid_q) begin
        in_use_q <= in_use_d;
      end
    end
  end

  // Names, counts and result payload.
  always_ff @(posedge clk_i) begin
    if (req_valid_q && key_we) begin
      key_q[wr_idx] <= name_q;
    end
    if (req_valid_q && cnt_we) begin
      count_q[wr_idx] <= cnt_wr;
    end
    if (req_valid_q) begin
      status_q  <= status_d;
      entry_q   <= entry_d;
      cnt_out_q <= cnt_out_d;
      wake_q    <= wake_d;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign entry_o       = entry_q;
  assign count_after_o = cnt_out_q;
  assign wake_waiter_o = wake_q;

endmodule
